@@ design/mlfq_tick_scheduler_core_defines.svh @@
// assertion macros for the mlfq tick scheduler checker
// expects i_clk and i_rst_n in the scope of use
`ifndef MLFQ_TICK_SCHEDULER_CORE_DEFINES_SVH
`define MLFQ_TICK_SCHEDULER_CORE_DEFINES_SVH

// clocked property, disabled during reset
`define MTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that holds at every edge
`define MTS_ASSERT_ALWAYS(lbl, cond, msg) `MTS_ASSERT(lbl, 1'b1 |-> (cond), msg)

`endif

@@ design/mts_pkg.sv @@
// shared types and constants of the mlfq tick scheduler
// no dependencies
package mts_pkg;

    localparam int LEVELS_DEF = 4;
    localparam int PROCS_DEF  = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int TF_W       = 16;
    localparam int TF_FIELDS  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_LEVELS   = 2'd0,
        CFG_BOOST_PERIOD = 2'd1,
        CFG_QUANTUM      = 2'd2,
        CFG_ALLOTMENT    = 2'd3
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BSCAN = 6'b000010,
        S_BPUSH = 6'b000100,
        S_DISP  = 6'b001000,
        S_DLOAD = 6'b010000,
        S_RUN   = 6'b100000
    } t_state;

    typedef struct packed {
        logic arrive;
        logic tick;
        logic boost_pop;
        logic boost_push;
        logic boost_cur;
        logic disp_pop;
        logic disp_load;
        logic run;
    } t_cmd;

    typedef struct packed {
        logic boost_due;
        logic boost_found;
        logic disp_found;
        logic cur_valid;
        logic out_free;
    } t_sts;

endpackage

@@ design/mts_ctrl.sv @@
// controller state machine of the mlfq tick scheduler
// depends on mts_pkg
module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_tick,
    output logic          o_in_ready,
    input  mts_pkg::t_sts i_sts,
    output mts_pkg::t_cmd o_cmd
);
    import mts_pkg::*;

    t_state r_state, n_state;
    logic   acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_in_tick) begin
                        o_cmd.tick = 1'b1;
                        n_state    = i_sts.boost_due ? S_BSCAN : S_DISP;
                    end else begin
                        o_cmd.arrive = 1'b1;
                    end
                end
            end
            S_BSCAN: begin
                if (i_sts.boost_found) begin
                    o_cmd.boost_pop = 1'b1;
                    n_state         = S_BPUSH;
                end else begin
                    o_cmd.boost_cur = 1'b1;
                    n_state         = S_DISP;
                end
            end
            S_BPUSH: begin
                o_cmd.boost_push = 1'b1;
                n_state          = S_BSCAN;
            end
            S_DISP: begin
                if (!i_sts.cur_valid && i_sts.disp_found) begin
                    o_cmd.disp_pop = 1'b1;
                    n_state        = S_DLOAD;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_DLOAD: begin
                o_cmd.disp_load = 1'b1;
                n_state         = S_RUN;
            end
            S_RUN: begin
                if (i_sts.out_free) begin
                    o_cmd.run = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ design/mts_dp.sv @@
// datapath of the mlfq tick scheduler: config, level queues, process table
// depends on mts_pkg
module mts_dp #(
    parameter int LEVELS = mts_pkg::LEVELS_DEF,
    parameter int PROCS  = mts_pkg::PROCS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [3:0]                       i_proc_id,
    input  logic [15:0]                      i_burst,
    input  mts_pkg::t_cmd                    i_cmd,
    output mts_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output logic [mts_pkg::OUT_DATA_W-1:0]   o_out_data,
    input  logic                             i_out_ready
);
    import mts_pkg::*;

    localparam int IW = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int CW = $clog2(PROCS + 1);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AW = $clog2(LEVELS * PROCS);

    function automatic logic [IW-1:0] id_wrap(input logic [3:0] v);
        int x;
        x = int'(v);
        for (int k = 0; k < 8; k++) begin
            if (x >= PROCS) x = x - PROCS;
        end
        return IW'(x);
    endfunction

    function automatic logic [IW-1:0] idx_wrap(input int s);
        int x;
        x = s;
        if (x >= PROCS) x = x - PROCS;
        return IW'(x);
    endfunction

    function automatic logic [TF_W-1:0] tfield(input logic [CFG_DATA_W-1:0] t,
                                              input logic [LW-1:0] l);
        logic [TF_W-1:0] f;
        f = '0;
        for (int k = 0; k < TF_FIELDS; k++) begin
            if (int'(l) == k) f = t[k*TF_W +: TF_W];
        end
        return f;
    endfunction

    logic [2:0]            r_num_levels;
    logic [15:0]           r_boost_period;
    logic [CFG_DATA_W-1:0] r_qtab, r_atab;

    logic [IW-1:0] r_head  [LEVELS];
    logic [CW-1:0] r_count [LEVELS];
    logic [IW-1:0] r_mem   [LEVELS*PROCS];
    logic [IW-1:0] r_rd;

    logic [15:0]   r_rem     [PROCS];
    logic [LW-1:0] r_lvl     [PROCS];
    logic [15:0]   r_tal     [PROCS];
    logic [PROCS-1:0] r_started;

    logic          r_cur_valid;
    logic [IW-1:0] r_cur_id;
    logic [15:0]   r_qc, r_bc;
    logic          r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic          boost_found, disp_found;
    logic [LW-1:0] boost_lvl, disp_lvl, pop_lvl, push_lvl;
    logic          pop_req, push_req, push_ok;
    logic [IW-1:0] push_id, arr_id;
    logic [AW-1:0] waddr, raddr;

    logic [LW-1:0] runlvl, new_lvl;
    logic [15:0]   rem_n, tal_n, qc_n, q, a;
    logic          fin, expire, dem;
    logic [3:0]    nl;
    logic          out_free;

    assign arr_id = id_wrap(i_proc_id);

    always_comb begin
        boost_found = 1'b0;
        boost_lvl   = '0;
        disp_found  = 1'b0;
        disp_lvl    = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                disp_found = 1'b1;
                disp_lvl   = LW'(l);
                if (l >= 1) begin
                    boost_found = 1'b1;
                    boost_lvl   = LW'(l);
                end
            end
        end
    end

    always_comb begin
        if (r_num_levels == 3'd0) nl = 4'd1;
        else if (int'(r_num_levels) > LEVELS) nl = 4'(LEVELS);
        else nl = {1'b0, r_num_levels};
    end

    always_comb begin
        runlvl = r_lvl[r_cur_id];
        rem_n  = (r_rem[r_cur_id] != 16'd0) ? r_rem[r_cur_id] - 16'd1 : 16'd0;
        tal_n  = (r_tal[r_cur_id] != 16'hFFFF) ? r_tal[r_cur_id] + 16'd1 : 16'hFFFF;
        qc_n   = (r_qc != 16'hFFFF) ? r_qc + 16'd1 : 16'hFFFF;
        q      = tfield(r_qtab, runlvl);
        a      = tfield(r_atab, runlvl);
        fin    = (rem_n == 16'd0);
        expire = !fin && (q != 16'd0) && (qc_n >= q);
        dem    = expire && (a != 16'd0) && (tal_n >= a)
                 && ((5'(runlvl) + 5'd1) < 5'(nl));
        new_lvl = dem ? runlvl + LW'(1) : runlvl;
    end

    always_comb begin
        push_req = 1'b0;
        push_lvl = '0;
        push_id  = arr_id;
        if (i_cmd.arrive) begin
            push_req = 1'b1;
        end else if (i_cmd.boost_push) begin
            push_req = 1'b1;
            push_id  = r_rd;
        end else if (i_cmd.boost_cur) begin
            push_req = r_cur_valid;
            push_id  = r_cur_id;
        end else if (i_cmd.run) begin
            push_req = r_cur_valid && expire;
            push_id  = r_cur_id;
            push_lvl = new_lvl;
        end
        push_ok = push_req && (int'(r_count[push_lvl]) < PROCS);
        waddr   = AW'(int'(push_lvl) * PROCS
                      + int'(idx_wrap(int'(r_head[push_lvl]) + int'(r_count[push_lvl]))));
        pop_req = i_cmd.boost_pop || i_cmd.disp_pop;
        pop_lvl = i_cmd.boost_pop ? boost_lvl : disp_lvl;
        raddr   = AW'(int'(pop_lvl) * PROCS + int'(r_head[pop_lvl]));
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[waddr] <= push_id;
        if (pop_req) r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            for (int l = 0; l < LEVELS; l++) begin
                if (push_ok && int'(push_lvl) == l) r_count[l] <= r_count[l] + CW'(1);
                if (pop_req && int'(pop_lvl) == l) begin
                    r_head[l]  <= idx_wrap(int'(r_head[l]) + 1);
                    r_count[l] <= r_count[l] - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arrive) begin
            r_rem[arr_id] <= i_burst;
            r_lvl[arr_id] <= '0;
            r_tal[arr_id] <= '0;
        end else if (i_cmd.boost_push) begin
            r_lvl[r_rd] <= '0;
            r_tal[r_rd] <= '0;
        end else if (i_cmd.boost_cur && r_cur_valid) begin
            r_lvl[r_cur_id] <= '0;
            r_tal[r_cur_id] <= '0;
        end else if (i_cmd.run && r_cur_valid) begin
            r_rem[r_cur_id] <= rem_n;
            r_lvl[r_cur_id] <= new_lvl;
            r_tal[r_cur_id] <= dem ? 16'd0 : tal_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels   <= 3'd3;
            r_boost_period <= '0;
            r_qtab         <= '0;
            r_atab         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_LEVELS:   r_num_levels   <= i_cfg_data[2:0];
                CFG_BOOST_PERIOD: r_boost_period <= i_cfg_data[15:0];
                CFG_QUANTUM:      r_qtab         <= i_cfg_data;
                CFG_ALLOTMENT:    r_atab         <= i_cfg_data;
                default:          r_num_levels   <= r_num_levels;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= '0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_qc        <= '0;
            r_bc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.arrive) r_started[arr_id] <= 1'b0;
            if (i_cmd.tick && !o_sts.boost_due && r_bc != 16'hFFFF) r_bc <= r_bc + 16'd1;
            if (i_cmd.boost_cur) begin
                r_bc        <= 16'd1;
                r_cur_valid <= 1'b0;
                r_qc        <= '0;
            end
            if (i_cmd.disp_load) begin
                r_cur_id    <= r_rd;
                r_cur_valid <= 1'b1;
                r_qc        <= '0;
            end
            if (i_cmd.run && r_cur_valid) begin
                r_started[r_cur_id] <= 1'b1;
                r_qc        <= (fin || expire) ? 16'd0 : qc_n;
                r_cur_valid <= !(fin || expire);
            end
            if (i_cmd.run) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run) begin
            if (r_cur_valid) begin
                r_out_data <= {6'd0, dem, fin, !r_started[r_cur_id], 2'(runlvl),
                               4'(r_cur_id), 1'b1};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_sts.boost_due   = (r_boost_period != 16'd0) && (r_bc >= r_boost_period);
    assign o_sts.boost_found = boost_found;
    assign o_sts.disp_found  = disp_found;
    assign o_sts.cur_valid   = r_cur_valid;
    assign o_sts.out_free    = out_free;
endmodule

@@ design/mlfq_tick_scheduler_core.sv @@
// top level of the mlfq tick scheduler
// depends on mts_pkg, mts_ctrl, mts_dp
// An arrival is taken in the idle state and gives no result. A tick passes the
// dispatch and run states, with a load state between them when a process is
// dispatched; a due boost adds a scan state, plus a scan and a push state for
// each entry it moves, as all level queues share one memory with one read and
// one write port. A new item is taken while the last result waits at the output.
module mlfq_tick_scheduler_core #(
    parameter int LEVELS = mts_pkg::LEVELS_DEF,
    parameter int PROCS  = mts_pkg::PROCS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [mts_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // proc_id, burst_length
    input  logic                           i_s_axis_tuser,  // req_type
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // cpu_busy, running_id, running_level, first_run, finished, demoted
    output logic [mts_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mts_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_tick  (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mts_dp #(.LEVELS(LEVELS), .PROCS(PROCS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_proc_id   (i_s_axis_tdata[3:0]),
        .i_burst     (i_s_axis_tdata[19:4]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .i_out_ready (i_m_axis_tready)
    );
endmodule

@@ design/mts_checker.sv @@
// port-level checker of the mlfq tick scheduler, bound to the top level
// depends on mts_pkg and mlfq_tick_scheduler_core_defines.svh
`include "mlfq_tick_scheduler_core_defines.svh"
module mts_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [mts_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    `MTS_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed while stalled")
    `MTS_ASSERT_ALWAYS(a_idle_zero, !o_m_axis_tvalid || o_m_axis_tdata[0] || o_m_axis_tdata[9:1] == 9'd0, "idle tick with nonzero fields")
    `MTS_ASSERT_ALWAYS(a_fin_dem, !o_m_axis_tvalid || !(o_m_axis_tdata[8] && o_m_axis_tdata[9]), "finished and demoted together")
    `MTS_ASSERT(a_arrival_silent, i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser && !o_m_axis_tvalid |=> !o_m_axis_tvalid, "arrival produced a result")
endmodule

bind mlfq_tick_scheduler_core mts_checker u_mts_checker (.*);
